/* rtl/sm3_pkg.sv */
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared constants and functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam int unsigned LEN_BITS = 61;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;

    localparam logic [255:0] IV = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic start;
    } comp_ctrl_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

/* rtl/sm3_stream_if.sv */
// ----------------------------------------------------------------------------
// sm3_stream_if
// Valid/ready channel interfaces of the SM3 hash engine.
// ----------------------------------------------------------------------------
interface sm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;

    modport source (output valid, data_word, byte_count, last, input ready);
    modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface sm3_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part;
    logic        digest_last;

    modport source (output valid, digest_part, digest_last, input ready);
    modport sink   (input valid, digest_part, digest_last, output ready);
endinterface

/* rtl/sm3_compress.sv */
// ----------------------------------------------------------------------------
// sm3_round_core
// Iterative SM3 compression: one round and one expansion word per cycle.
// ----------------------------------------------------------------------------
module sm3_round_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sm3_pkg::comp_ctrl_t   ctrl_in,
    input  logic [511:0]          block,
    input  logic [255:0]          cv_in,
    output logic [255:0]          cv_out,
    output logic                  done
);

    logic [31:0] w_reg [16];
    logic [31:0] r_reg [8];
    logic [5:0]  round_reg;
    logic        run_reg;
    logic        done_reg;

    logic [3:0]  jx, nx, i16, i9, i3, i13, i6;
    logic [31:0] x_w, w_new, w_n, w_j, t_c, a12, ss1, ss2, ff, gg, tt1, tt2;
    logic [5:0]  n6;

    always_comb
    begin
        jx  = round_reg[3:0];
        n6  = round_reg + 6'd4;
        nx  = n6[3:0];
        i16 = nx;
        i9  = nx - 4'd9;
        i3  = nx - 4'd3;
        i13 = nx - 4'd13;
        i6  = nx - 4'd6;
        x_w = w_reg[i16] ^ w_reg[i9] ^ sm3_pkg::rotl(w_reg[i3], 5'd15);
        w_new = sm3_pkg::perm1(x_w) ^ sm3_pkg::rotl(w_reg[i13], 5'd7) ^ w_reg[i6];
        w_n = (round_reg >= 6'd12) ? w_new : w_reg[nx];
        w_j = w_reg[jx];
        t_c = (round_reg < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
        a12 = sm3_pkg::rotl(r_reg[0], 5'd12);
        ss1 = sm3_pkg::rotl(a12 + r_reg[4] + sm3_pkg::rotl(t_c, round_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (round_reg < 6'd16)
        begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end
        else
        begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (w_j ^ w_n);
        tt2 = gg + r_reg[7] + ss1 + w_j;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl_in.start && !run_reg)
            begin
                run_reg   <= 1'b1;
                round_reg <= '0;
            end
            else if (run_reg)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.start && !run_reg)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= block[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++)
            begin
                r_reg[i] <= cv_in[255 - 32*i -: 32];
            end
        end
        else if (run_reg)
        begin
            if (round_reg >= 6'd12)
            begin
                w_reg[nx] <= w_new;
            end
            r_reg[3] <= r_reg[2];
            r_reg[2] <= sm3_pkg::rotl(r_reg[1], 5'd9);
            r_reg[1] <= r_reg[0];
            r_reg[0] <= tt1;
            r_reg[7] <= r_reg[6];
            r_reg[6] <= sm3_pkg::rotl(r_reg[5], 5'd19);
            r_reg[5] <= r_reg[4];
            r_reg[4] <= sm3_pkg::perm0(tt2);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cv_out[255 - 32*i -: 32] = cv_in[255 - 32*i -: 32] ^ r_reg[i];
        end
    end

    assign done = done_reg;

endmodule

/* rtl/sm3_hash_engine.sv */
// ----------------------------------------------------------------------------
// sm3_hash_engine
// Streaming SM3 hash with padding and 64-bit length trailer.
// ----------------------------------------------------------------------------
// Input channel: one big-endian 32-bit message word per transfer, with the
// count of valid leading bytes and a last flag. A count below 4 is allowed
// only on the last word. Output channel: four 64-bit digest parts, most
// significant first, digest_last on the fourth.
// A word that does not finish a block leaves the input ready for the next
// word. The sixteenth word of a block starts a compression in the shared
// round unit: a load, 64 rounds and a handoff, with the input stalled
// throughout. The last word adds padding: padding words written one per
// cycle, one or two compressed blocks, then four digest transfers.
// The input is not ready during compression, padding or digest output.
// When the receiver stalls, the current digest part holds until taken.
// Reset loads the standard IV, clears the word and byte counters and makes
// the engine ready for a new message. After the digest the same happens.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
    input  logic      clk,
    input  logic      rst_n,
    sm3_in_if.sink    in_ch,
    sm3_out_if.source out_ch
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_PAD,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] blk_reg [16];
    logic [3:0]  wcnt_reg;
    logic [sm3_pkg::LEN_BITS-1:0] total_reg;
    logic [255:0] cv_reg;
    logic         pad_reg;
    logic         fin_reg;
    logic         start_reg;
    logic [1:0]   part_reg;
    logic [63:0]  bits_w;
    logic [511:0] block_w;
    logic [255:0] cv_new;
    logic         done_w;
    logic [2:0]   cnt_w;
    logic [31:0]  keep_w, padw_w, pad_src_w;
    sm3_pkg::comp_ctrl_t ctrl;

    assign ctrl.start = start_reg;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            block_w[511 - 32*i -: 32] = blk_reg[i];
        end
    end

    sm3_round_core u_comp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (ctrl),
        .block   (block_w),
        .cv_in   (cv_reg),
        .cv_out  (cv_new),
        .done    (done_w)
    );

    // fin_reg: the length trailer goes into the block being filled
    always_comb
    begin
        cnt_w = (!in_ch.last || in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
        unique case (cnt_w)
            3'd0:    keep_w = 32'h0;
            3'd1:    keep_w = 32'hff000000;
            3'd2:    keep_w = 32'hffff0000;
            3'd3:    keep_w = 32'hffffff00;
            default: keep_w = 32'hffffffff;
        endcase
        padw_w = {24'h0, sm3_pkg::PAD_BYTE} << (5'd24 - {cnt_w[1:0], 3'b000});
        bits_w = 64'({total_reg, 3'b000});
        priority if (pad_reg)
            pad_src_w = {sm3_pkg::PAD_BYTE, 24'h0};
        else if (fin_reg && wcnt_reg == 4'd14)
            pad_src_w = bits_w[63:32];
        else if (fin_reg && wcnt_reg == 4'd15)
            pad_src_w = bits_w[31:0];
        else
            pad_src_w = 32'h0;
    end

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.digest_part = cv_reg[255 - 64*part_reg -: 64];
    assign out_ch.digest_last = (part_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wcnt_reg  <= '0;
            total_reg <= '0;
            cv_reg    <= sm3_pkg::IV;
            pad_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            start_reg <= 1'b0;
            part_reg  <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        total_reg <= total_reg + sm3_pkg::LEN_BITS'(cnt_w);
                        if (!in_ch.last)
                        begin
                            blk_reg[wcnt_reg] <= in_ch.data_word;
                            wcnt_reg <= wcnt_reg + 4'd1;
                            if (wcnt_reg == 4'd15)
                            begin
                                start_reg <= 1'b1;
                                state_reg <= S_COMP;
                            end
                        end
                        else if (cnt_w == 3'd4)
                        begin
                            blk_reg[wcnt_reg] <= in_ch.data_word;
                            wcnt_reg <= wcnt_reg + 4'd1;
                            pad_reg  <= 1'b1;
                            if (wcnt_reg == 4'd15)
                            begin
                                start_reg <= 1'b1;
                                state_reg <= S_COMP;
                            end
                            else
                            begin
                                state_reg <= S_PAD;
                            end
                        end
                        else
                        begin
                            blk_reg[wcnt_reg] <= (in_ch.data_word & keep_w) | padw_w;
                            wcnt_reg <= wcnt_reg + 4'd1;
                            pad_reg  <= 1'b0;
                            fin_reg  <= (wcnt_reg < 4'd14);
                            if (wcnt_reg == 4'd15)
                            begin
                                start_reg <= 1'b1;
                                state_reg <= S_COMP;
                            end
                            else
                            begin
                                state_reg <= S_PAD;
                            end
                        end
                        if (in_ch.last)
                        begin
                            part_reg <= 2'd1;
                        end
                        else
                        begin
                            part_reg <= 2'd0;
                        end
                    end
                end
                S_COMP:
                begin
                    if (done_w)
                    begin
                        cv_reg   <= cv_new;
                        wcnt_reg <= '0;
                        if (part_reg == 2'd2)
                        begin
                            part_reg  <= 2'd0;
                            state_reg <= S_OUT;
                        end
                        else if (part_reg == 2'd1)
                        begin
                            fin_reg   <= 1'b1;
                            state_reg <= S_PAD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_PAD:
                begin
                    blk_reg[wcnt_reg] <= pad_src_w;
                    pad_reg  <= 1'b0;
                    if (pad_reg)
                    begin
                        fin_reg <= (wcnt_reg < 4'd14);
                    end
                    wcnt_reg <= wcnt_reg + 4'd1;
                    if (wcnt_reg == 4'd15)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= S_COMP;
                        part_reg  <= (fin_reg && !pad_reg) ? 2'd2 : 2'd1;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        part_reg <= part_reg + 2'd1;
                        if (part_reg == 2'd3)
                        begin
                            state_reg <= S_IDLE;
                            cv_reg    <= sm3_pkg::IV;
                            wcnt_reg  <= '0;
                            total_reg <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
